@@ rtl/akf_pkg.sv @@
// Shared constants, types and helper functions for the attitude filter.
`timescale 1ns / 1ps
`default_nettype none
package akf_pkg;

    localparam int AXES         = 3;
    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;

    localparam int ATAN_ENTRIES = 24;
    localparam int CSTEPS       = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int SQRT_STEPS   = 16;
    localparam int DIV_BITS     = 32 + FRAC_BITS;
    localparam int CNT_W        = $clog2(DIV_BITS);
    localparam int MUL_W        = 34;
    localparam int RAD_LIMIT    = 205887;
    localparam logic signed [MUL_W-1:0] DEG2RAD = 34'sd74961321;

    localparam int ONE_INT     = 1 << FRAC_BITS;
    localparam int Q_ANGLE_RST = ((ONE_INT + 500) / 1000) % 65536;
    localparam int Q_BIAS_RST  = ((3 * ONE_INT + 500) / 1000) % 65536;
    localparam int R_MEAS_RST  = (ONE_INT > 16777215) ? 16777215 : ONE_INT;

    localparam logic [1:0] CFG_Q_ANGLE = 2'd0;
    localparam logic [1:0] CFG_Q_BIAS  = 2'd1;
    localparam logic [1:0] CFG_R_MEAS  = 2'd2;

    typedef logic signed [71:0] wide_t;

    typedef enum logic [5:0] {
        S_IDLE, S_SQ_A, S_SQ_AW, S_SQ_B, S_SQ_BW, S_SQ_C, S_SQRT,
        S_CORD_INIT, S_CORD, S_MEAS,
        S_A0, S_A1, S_A2, S_A3, S_A4, S_A5, S_A6, S_A7,
        S_DIV0_INIT, S_DIV0, S_K0, S_DIV1_INIT, S_DIV1, S_K1,
        S_A11, S_A12, S_A13, S_A14, S_A15, S_A16, S_A17,
        S_O0, S_O1, S_O2, S_O3
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_SQ_A, OP_SQ_B, OP_SQ_C, OP_SQRT, OP_CORD_INIT, OP_CORD,
        OP_MEAS, OP_RATE, OP_LD_CROSS, OP_ANG_PRED, OP_T2, OP_T3, OP_COV_PRED,
        OP_INNOV, OP_DIV_INIT, OP_DIV, OP_K0, OP_K1, OP_LD_K0, OP_LD_K1,
        OP_UPD_ANG, OP_UPD_BIAS, OP_UPD_PA, OP_UPD_PC, OP_UPD_PB,
        OP_OUT_0, OP_OUT_1, OP_OUT_2, OP_OUT_3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             sel;
        logic [1:0]       axis;
        logic [CNT_W-1:0] cnt;
        logic             in_ready;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    function automatic logic signed [31:0] sat32(input wide_t v);
        logic signed [31:0] r;
        if (v > 72'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -72'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic [21:0] atan_q16(input logic [4:0] i);
        logic [21:0] r;
        case (i)
            5'd0:  r = 22'd2949120;
            5'd1:  r = 22'd1740967;
            5'd2:  r = 22'd919879;
            5'd3:  r = 22'd466945;
            5'd4:  r = 22'd234379;
            5'd5:  r = 22'd117304;
            5'd6:  r = 22'd58666;
            5'd7:  r = 22'd29335;
            5'd8:  r = 22'd14668;
            5'd9:  r = 22'd7334;
            5'd10: r = 22'd3667;
            5'd11: r = 22'd1833;
            5'd12: r = 22'd917;
            5'd13: r = 22'd458;
            5'd14: r = 22'd229;
            5'd15: r = 22'd115;
            5'd16: r = 22'd57;
            5'd17: r = 22'd29;
            5'd18: r = 22'd14;
            5'd19: r = 22'd7;
            5'd20: r = 22'd4;
            5'd21: r = 22'd2;
            5'd22: r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/akf_ctrl.sv @@
// Sequencer for the attitude filter: steps the datapath through each word.
`timescale 1ns / 1ps
`default_nettype none
module akf_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire akf_pkg::status_t st,
    output akf_pkg::cmd_t        cmd
);

    akf_pkg::state_t state_reg, state_next;
    logic [akf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic       sel_reg, sel_next;
    logic [1:0] axis_reg, axis_next;

    localparam logic [akf_pkg::CNT_W-1:0] SQRT_LAST = akf_pkg::CNT_W'(akf_pkg::SQRT_STEPS - 1);
    localparam logic [akf_pkg::CNT_W-1:0] CORD_LAST = akf_pkg::CNT_W'(akf_pkg::CSTEPS - 1);
    localparam logic [akf_pkg::CNT_W-1:0] DIV_LAST  = akf_pkg::CNT_W'(akf_pkg::DIV_BITS - 1);
    localparam logic [1:0] AXIS_LAST = 2'(akf_pkg::AXES - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= akf_pkg::S_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            akf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = akf_pkg::S_SQ_A;
                    sel_next   = 1'b0;
                    axis_next  = 2'd0;
                    cnt_next   = '0;
                end
            end
            akf_pkg::S_SQ_A:  state_next = akf_pkg::S_SQ_AW;
            akf_pkg::S_SQ_AW: state_next = akf_pkg::S_SQ_B;
            akf_pkg::S_SQ_B:  state_next = akf_pkg::S_SQ_BW;
            akf_pkg::S_SQ_BW: state_next = akf_pkg::S_SQ_C;
            akf_pkg::S_SQ_C:  state_next = akf_pkg::S_SQRT;
            akf_pkg::S_SQRT:
            begin
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = akf_pkg::S_CORD_INIT;
                end
                else cnt_next = cnt_reg + 1'b1;
            end
            akf_pkg::S_CORD_INIT: state_next = akf_pkg::S_CORD;
            akf_pkg::S_CORD:
            begin
                if (cnt_reg == CORD_LAST)
                begin
                    cnt_next   = '0;
                    state_next = akf_pkg::S_MEAS;
                end
                else cnt_next = cnt_reg + 1'b1;
            end
            akf_pkg::S_MEAS:
            begin
                if (sel_reg) state_next = akf_pkg::S_A0;
                else
                begin
                    sel_next   = 1'b1;
                    state_next = akf_pkg::S_SQ_A;
                end
            end
            akf_pkg::S_A0: state_next = akf_pkg::S_A1;
            akf_pkg::S_A1: state_next = akf_pkg::S_A2;
            akf_pkg::S_A2: state_next = akf_pkg::S_A3;
            akf_pkg::S_A3: state_next = akf_pkg::S_A4;
            akf_pkg::S_A4: state_next = akf_pkg::S_A5;
            akf_pkg::S_A5: state_next = akf_pkg::S_A6;
            akf_pkg::S_A6: state_next = akf_pkg::S_A7;
            akf_pkg::S_A7: state_next = akf_pkg::S_DIV0_INIT;
            akf_pkg::S_DIV0_INIT: state_next = akf_pkg::S_DIV0;
            akf_pkg::S_DIV0:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = akf_pkg::S_K0;
                end
                else cnt_next = cnt_reg + 1'b1;
            end
            akf_pkg::S_K0: state_next = akf_pkg::S_DIV1_INIT;
            akf_pkg::S_DIV1_INIT: state_next = akf_pkg::S_DIV1;
            akf_pkg::S_DIV1:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = akf_pkg::S_K1;
                end
                else cnt_next = cnt_reg + 1'b1;
            end
            akf_pkg::S_K1:  state_next = akf_pkg::S_A11;
            akf_pkg::S_A11: state_next = akf_pkg::S_A12;
            akf_pkg::S_A12: state_next = akf_pkg::S_A13;
            akf_pkg::S_A13: state_next = akf_pkg::S_A14;
            akf_pkg::S_A14: state_next = akf_pkg::S_A15;
            akf_pkg::S_A15: state_next = akf_pkg::S_A16;
            akf_pkg::S_A16: state_next = akf_pkg::S_A17;
            akf_pkg::S_A17:
            begin
                if (axis_reg == AXIS_LAST) state_next = akf_pkg::S_O0;
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = akf_pkg::S_A0;
                end
            end
            akf_pkg::S_O0: state_next = akf_pkg::S_O1;
            akf_pkg::S_O1: state_next = akf_pkg::S_O2;
            akf_pkg::S_O2: state_next = akf_pkg::S_O3;
            akf_pkg::S_O3:
            begin
                if (!st.out_busy) state_next = akf_pkg::S_IDLE;
            end
            default: state_next = akf_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.sel      = sel_reg;
        cmd.axis     = axis_reg;
        cmd.cnt      = cnt_reg;
        cmd.in_ready = 1'b0;
        cmd.op       = akf_pkg::OP_NONE;
        unique case (state_reg)
            akf_pkg::S_IDLE:      cmd.in_ready = 1'b1;
            akf_pkg::S_SQ_A:      cmd.op = akf_pkg::OP_SQ_A;
            akf_pkg::S_SQ_B:      cmd.op = akf_pkg::OP_SQ_B;
            akf_pkg::S_SQ_C:      cmd.op = akf_pkg::OP_SQ_C;
            akf_pkg::S_SQRT:      cmd.op = akf_pkg::OP_SQRT;
            akf_pkg::S_CORD_INIT: cmd.op = akf_pkg::OP_CORD_INIT;
            akf_pkg::S_CORD:      cmd.op = akf_pkg::OP_CORD;
            akf_pkg::S_MEAS:      cmd.op = akf_pkg::OP_MEAS;
            akf_pkg::S_A0:        cmd.op = akf_pkg::OP_RATE;
            akf_pkg::S_A1:        cmd.op = akf_pkg::OP_LD_CROSS;
            akf_pkg::S_A2:        cmd.op = akf_pkg::OP_ANG_PRED;
            akf_pkg::S_A3:        cmd.op = akf_pkg::OP_T2;
            akf_pkg::S_A4:        cmd.op = akf_pkg::OP_T3;
            akf_pkg::S_A6:        cmd.op = akf_pkg::OP_COV_PRED;
            akf_pkg::S_A7:        cmd.op = akf_pkg::OP_INNOV;
            akf_pkg::S_DIV0_INIT:
            begin
                cmd.op  = akf_pkg::OP_DIV_INIT;
                cmd.sel = 1'b0;
            end
            akf_pkg::S_DIV1_INIT:
            begin
                cmd.op  = akf_pkg::OP_DIV_INIT;
                cmd.sel = 1'b1;
            end
            akf_pkg::S_DIV0, akf_pkg::S_DIV1: cmd.op = akf_pkg::OP_DIV;
            akf_pkg::S_K0:  cmd.op = akf_pkg::OP_K0;
            akf_pkg::S_K1:  cmd.op = akf_pkg::OP_K1;
            akf_pkg::S_A11: cmd.op = akf_pkg::OP_LD_K0;
            akf_pkg::S_A12: cmd.op = akf_pkg::OP_LD_K1;
            akf_pkg::S_A13: cmd.op = akf_pkg::OP_UPD_ANG;
            akf_pkg::S_A14: cmd.op = akf_pkg::OP_UPD_BIAS;
            akf_pkg::S_A15: cmd.op = akf_pkg::OP_UPD_PA;
            akf_pkg::S_A16: cmd.op = akf_pkg::OP_UPD_PC;
            akf_pkg::S_A17: cmd.op = akf_pkg::OP_UPD_PB;
            akf_pkg::S_O0:  cmd.op = akf_pkg::OP_OUT_0;
            akf_pkg::S_O1:  cmd.op = akf_pkg::OP_OUT_1;
            akf_pkg::S_O2:  cmd.op = akf_pkg::OP_OUT_2;
            akf_pkg::S_O3:  cmd.op = st.out_busy ? akf_pkg::OP_NONE : akf_pkg::OP_OUT_3;
            default:        cmd.op = akf_pkg::OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/akf_dp.sv @@
// Datapath of the attitude filter: state, shared multiplier, root, CORDIC and divider.
`timescale 1ns / 1ps
`default_nettype none
module akf_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire akf_pkg::cmd_t  cmd,
    output akf_pkg::status_t    st,
    input  wire logic           in_valid,
    input  wire logic [191:0]   in_data,
    input  wire logic           cfg_valid,
    input  wire logic [1:0]     cfg_addr,
    input  wire logic [23:0]    cfg_data,
    input  wire logic           out_ready,
    output logic                out_valid,
    output logic [71:0]         out_data
);

    localparam int F  = akf_pkg::FRAC_BITS;
    localparam int DW = akf_pkg::DIV_BITS;
    localparam logic signed [31:0] ONE = 32'sd1 <<< F;

    logic [15:0] q_angle_reg, q_bias_reg;
    logic [23:0] r_meas_reg;

    logic signed [31:0] est_ang_reg [3];
    logic signed [31:0] est_bias_reg [3];
    logic signed [31:0] cov_a_reg [3];
    logic signed [31:0] cov_c_reg [3];
    logic signed [31:0] cov_b_reg [3];

    logic signed [31:0] gx_reg, gy_reg, gz_reg, hd_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic [15:0]        dt_reg;

    logic signed [akf_pkg::MUL_W-1:0]   ma_reg, mb_reg;
    logic signed [2*akf_pkg::MUL_W-1:0] prod_reg;

    logic signed [31:0] ang_reg, p00_reg, p01_reg, p11_reg, innov_reg, k0_reg, k1_reg;
    logic signed [33:0] t2_reg, t3_reg, s_reg;
    logic signed [31:0] meas_reg [2];
    logic signed [18:0] rad0_reg;

    logic [31:0] sq_reg, root_reg, bit_reg;
    logic signed [32:0] cx_reg, cy_reg;
    logic signed [31:0] cz_reg;
    logic               czero_reg;

    logic [DW-1:0] dnum_reg;
    logic [31:0]   drem_reg;
    logic          dneg_reg;

    logic               out_valid_reg;
    logic signed [18:0] out_roll_reg, out_pitch_reg;
    logic signed [31:0] out_yaw_reg;

    akf_pkg::wide_t prod_w, mdt_w, mq_w, rad_w;
    logic signed [31:0] mq;
    logic signed [18:0] rad;
    logic signed [33:0] rate_w, dt_op;
    logic signed [31:0] omk, meas_sel, cz_scaled, p_sel;
    logic signed [32:0] p_abs;
    logic [32:0] sqrt_trial, div_shift;
    logic signed [32:0] cdx, cdy;
    logic [4:0] cidx;
    logic signed [31:0] k_val;
    logic s_pos;
    logic [1:0] ax_i;

    assign ax_i   = cmd.axis;
    assign prod_w = 72'(prod_reg);
    assign mdt_w  = (prod_w + 72'sd32768) >>> 16;
    assign mq_w   = (prod_w + (72'sd1 <<< (F - 1))) >>> F;
    assign mq     = akf_pkg::sat32(mq_w);
    assign rad_w  = (prod_w + (72'sd1 <<< 31)) >>> 32;
    assign dt_op  = $signed({18'd0, dt_reg});
    assign omk    = akf_pkg::sat32(72'(ONE) - 72'(k0_reg));
    assign s_pos  = !s_reg[33] && (s_reg != 34'sd0);
    assign cidx   = cmd.cnt[4:0];
    assign cdx    = cx_reg >>> cidx;
    assign cdy    = cy_reg >>> cidx;
    assign sqrt_trial = {1'b0, root_reg} + {1'b0, bit_reg};
    assign div_shift  = {drem_reg, dnum_reg[DW-1]};
    assign p_sel  = cmd.sel ? p01_reg : p00_reg;
    assign p_abs  = p_sel[31] ? -33'(p_sel) : 33'(p_sel);

    always_comb
    begin
        if (rad_w > 72'(akf_pkg::RAD_LIMIT)) rad = 19'(akf_pkg::RAD_LIMIT);
        else if (rad_w < -72'(akf_pkg::RAD_LIMIT)) rad = -19'(akf_pkg::RAD_LIMIT);
        else rad = rad_w[18:0];
    end

    always_comb
    begin
        case (ax_i)
            2'd0:    rate_w = 34'(gx_reg);
            2'd1:    rate_w = -34'(gy_reg);
            default: rate_w = -34'(gz_reg);
        endcase
        case (ax_i)
            2'd0:    meas_sel = meas_reg[0];
            2'd1:    meas_sel = meas_reg[1];
            default: meas_sel = hd_reg;
        endcase
    end

    always_comb
    begin
        if (F >= 16) cz_scaled = cz_reg <<< (F - 16);
        else cz_scaled = cz_reg >>> (16 - F);
    end

    always_comb
    begin
        if (dneg_reg)
        begin
            if (dnum_reg > DW'(64'd2147483648)) k_val = 32'sh80000000;
            else k_val = -dnum_reg[31:0];
        end
        else
        begin
            if (dnum_reg > DW'(64'd2147483647)) k_val = 32'sh7FFFFFFF;
            else k_val = dnum_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_angle_reg   <= 16'(akf_pkg::Q_ANGLE_RST);
            q_bias_reg    <= 16'(akf_pkg::Q_BIAS_RST);
            r_meas_reg    <= 24'(akf_pkg::R_MEAS_RST);
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                est_ang_reg[i]  <= '0;
                est_bias_reg[i] <= '0;
                cov_a_reg[i]    <= ONE;
                cov_c_reg[i]    <= '0;
                cov_b_reg[i]    <= ONE;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_addr)
                    akf_pkg::CFG_Q_ANGLE: q_angle_reg <= cfg_data[15:0];
                    akf_pkg::CFG_Q_BIAS:  q_bias_reg  <= cfg_data[15:0];
                    akf_pkg::CFG_R_MEAS:  r_meas_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == akf_pkg::OP_OUT_3) out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            case (cmd.op)
                akf_pkg::OP_UPD_ANG:
                    est_ang_reg[ax_i] <= akf_pkg::sat32(72'(ang_reg) + 72'(mq));
                akf_pkg::OP_UPD_BIAS:
                    est_bias_reg[ax_i] <= akf_pkg::sat32(72'(est_bias_reg[ax_i]) + 72'(mq));
                akf_pkg::OP_UPD_PA: cov_a_reg[ax_i] <= mq;
                akf_pkg::OP_UPD_PC: cov_c_reg[ax_i] <= mq;
                akf_pkg::OP_UPD_PB:
                    cov_b_reg[ax_i] <= akf_pkg::sat32(72'(p11_reg) - 72'(mq));
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma_reg * mb_reg;
        if (cmd.in_ready && in_valid)
        begin
            gx_reg <= in_data[31:0];
            gy_reg <= in_data[63:32];
            gz_reg <= in_data[95:64];
            ax_reg <= in_data[111:96];
            ay_reg <= in_data[127:112];
            az_reg <= in_data[143:128];
            hd_reg <= in_data[175:144];
            dt_reg <= in_data[191:176];
        end
        case (cmd.op)
            akf_pkg::OP_SQ_A:
            begin
                ma_reg <= cmd.sel ? 34'(ay_reg) : 34'(ax_reg);
                mb_reg <= cmd.sel ? 34'(ay_reg) : 34'(ax_reg);
            end
            akf_pkg::OP_SQ_B:
            begin
                sq_reg <= prod_reg[31:0];
                ma_reg <= 34'(az_reg);
                mb_reg <= 34'(az_reg);
            end
            akf_pkg::OP_SQ_C:
            begin
                sq_reg   <= sq_reg + prod_reg[31:0];
                root_reg <= '0;
                bit_reg  <= 32'd1 << 30;
            end
            akf_pkg::OP_SQRT:
            begin
                if ({1'b0, sq_reg} >= sqrt_trial)
                begin
                    sq_reg   <= sq_reg - sqrt_trial[31:0];
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            akf_pkg::OP_CORD_INIT:
            begin
                cx_reg    <= $signed({1'b0, root_reg[15:0], 14'd0}) <<< 2 >>> 2;
                cy_reg    <= 33'(cmd.sel ? ax_reg : ay_reg) <<< 14;
                cz_reg    <= '0;
                czero_reg <= (root_reg[15:0] == 16'd0) &&
                             ((cmd.sel ? ax_reg : ay_reg) == 16'sd0);
            end
            akf_pkg::OP_CORD:
            begin
                if (!cy_reg[32])
                begin
                    cx_reg <= cx_reg + cdy;
                    cy_reg <= cy_reg - cdx;
                    cz_reg <= cz_reg + $signed({10'd0, akf_pkg::atan_q16(cidx)});
                end
                else
                begin
                    cx_reg <= cx_reg - cdy;
                    cy_reg <= cy_reg + cdx;
                    cz_reg <= cz_reg - $signed({10'd0, akf_pkg::atan_q16(cidx)});
                end
            end
            akf_pkg::OP_MEAS: meas_reg[cmd.sel] <= czero_reg ? 32'sd0 : cz_scaled;
            akf_pkg::OP_RATE:
            begin
                ma_reg <= rate_w - 34'(est_bias_reg[ax_i]);
                mb_reg <= dt_op;
            end
            akf_pkg::OP_LD_CROSS:
            begin
                ma_reg <= 34'(cov_c_reg[ax_i]);
                mb_reg <= dt_op;
            end
            akf_pkg::OP_ANG_PRED:
            begin
                ang_reg <= akf_pkg::sat32(72'(est_ang_reg[ax_i]) + mdt_w);
                ma_reg  <= 34'(cov_b_reg[ax_i]);
                mb_reg  <= dt_op;
            end
            akf_pkg::OP_T2: t2_reg <= mdt_w[33:0];
            akf_pkg::OP_T3:
            begin
                t3_reg <= mdt_w[33:0];
                ma_reg <= mdt_w[33:0];
                mb_reg <= dt_op;
            end
            akf_pkg::OP_COV_PRED:
            begin
                p00_reg <= akf_pkg::sat32(72'(cov_a_reg[ax_i]) - (72'(t2_reg) <<< 1) + mdt_w
                                          + 72'($signed({1'b0, q_angle_reg})));
                p01_reg <= akf_pkg::sat32(72'(cov_c_reg[ax_i]) - 72'(t3_reg));
                p11_reg <= akf_pkg::sat32(72'(cov_b_reg[ax_i])
                                          + 72'($signed({1'b0, q_bias_reg})));
            end
            akf_pkg::OP_INNOV:
            begin
                s_reg     <= 34'(p00_reg) + 34'($signed({1'b0, r_meas_reg}));
                innov_reg <= akf_pkg::sat32(72'(meas_sel) - 72'(ang_reg));
            end
            akf_pkg::OP_DIV_INIT:
            begin
                dnum_reg <= {p_abs[31:0], F'(0)};
                drem_reg <= '0;
                dneg_reg <= p_sel[31];
            end
            akf_pkg::OP_DIV:
            begin
                if (div_shift >= {1'b0, s_reg[31:0]})
                begin
                    drem_reg <= 32'(div_shift - {1'b0, s_reg[31:0]});
                    dnum_reg <= {dnum_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= div_shift[31:0];
                    dnum_reg <= {dnum_reg[DW-2:0], 1'b0};
                end
            end
            akf_pkg::OP_K0: k0_reg <= s_pos ? k_val : 32'sd0;
            akf_pkg::OP_K1: k1_reg <= s_pos ? k_val : 32'sd0;
            akf_pkg::OP_LD_K0:
            begin
                ma_reg <= 34'(k0_reg);
                mb_reg <= 34'(innov_reg);
            end
            akf_pkg::OP_LD_K1:
            begin
                ma_reg <= 34'(k1_reg);
                mb_reg <= 34'(innov_reg);
            end
            akf_pkg::OP_UPD_ANG:
            begin
                ma_reg <= 34'(omk);
                mb_reg <= 34'(p00_reg);
            end
            akf_pkg::OP_UPD_BIAS:
            begin
                ma_reg <= 34'(omk);
                mb_reg <= 34'(p01_reg);
            end
            akf_pkg::OP_UPD_PA:
            begin
                ma_reg <= 34'(k1_reg);
                mb_reg <= 34'(p01_reg);
            end
            akf_pkg::OP_OUT_0:
            begin
                ma_reg <= 34'(est_ang_reg[0]);
                mb_reg <= akf_pkg::DEG2RAD;
            end
            akf_pkg::OP_OUT_1:
            begin
                ma_reg <= 34'(est_ang_reg[1]);
                mb_reg <= akf_pkg::DEG2RAD;
            end
            akf_pkg::OP_OUT_2: rad0_reg <= rad;
            akf_pkg::OP_OUT_3:
            begin
                out_roll_reg  <= rad0_reg;
                out_pitch_reg <= (akf_pkg::AXES > 1) ? rad : 19'sd0;
                out_yaw_reg   <= (akf_pkg::AXES > 2) ? est_ang_reg[2] : 32'sd0;
            end
            default: ;
        endcase
    end

    assign st.out_busy = out_valid_reg && !out_ready;
    assign out_valid   = out_valid_reg;
    assign out_data    = {2'b00, out_yaw_reg, out_pitch_reg, out_roll_reg};

endmodule
`default_nettype wire

@@ rtl/attitude_kalman_filter_top.sv @@
// Top level of the gyro-bias attitude filter: sequencer plus datapath.
//
//  channel   direction  width  handshake
//  s_axis    in         192    s_axis_tvalid / s_axis_tready
//  m_axis    out        72     m_axis_tvalid / m_axis_tready
//  cfg       in         2+24   cfg_valid / cfg_ready
//
// The restoring gain divider, one quotient bit per cycle and run twice per axis,
// sets most of the time that one word takes.
// Reset clears the filter state to its initial covariance and the registers to defaults.
// A new word is taken once the previous one is finished; the result register holds
// while m_axis_tready is low, and only the final write of a result waits on it.
`timescale 1ns / 1ps
`default_nettype none
module attitude_kalman_filter_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, heading, step_time
    input  wire logic [191:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // roll_rad, pitch_rad, yaw_deg, two zero bits
    output logic [71:0]       m_axis_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [23:0]  cfg_data
);

    akf_pkg::cmd_t    cmd;
    akf_pkg::status_t st;

    akf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .st       (st),
        .cmd      (cmd)
    );

    akf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

    assign s_axis_tready = cmd.in_ready;
    assign cfg_ready     = 1'b1;

endmodule
`default_nettype wire

@@ tb/akf_checker.sv @@
// Checker for the attitude filter: tracks the register writes, predicts each result and compares.
`timescale 1ns / 1ps
module akf_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [71:0]  m_axis_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_addr,
    input  logic [23:0]  cfg_data,
    output int           errors,
    output int           pending,
    output int           matched
);
    import akf_pkg::*;

    typedef struct {
        logic signed [18:0] roll;
        logic signed [18:0] pitch;
        logic signed [31:0] yaw;
    } attitude_t;

    localparam longint ONE  = longint'(1) << FRAC_BITS;
    localparam longint IMAX = 64'sd2147483647;
    localparam longint IMIN = -64'sd2147483648;

    localparam longint ATAN_DEG [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    attitude_t attitude_q[$];

    longint unsigned q_angle_r, q_bias_r, r_meas_r;
    longint ang_est [3];
    longint bias_est [3];
    longint p_aa [3];
    longint p_ab [3];
    longint p_bb [3];

    function automatic longint clip32(input longint v);
        if (v > IMAX) return IMAX;
        if (v < IMIN) return IMIN;
        return v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return clip32((a * b + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS);
    endfunction

    function automatic longint by_dt(input longint v, input longint dt);
        return (v * dt + 32768) >>> 16;
    endfunction

    function automatic longint int_root(input longint unsigned n_in);
        longint unsigned n, res, b;
        n = n_in;
        res = 0;
        b = 64'd1 << 30;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint tilt_deg(input longint y_in, input longint x_in);
        longint x, y, z, dx, dy;
        int sh;
        x = x_in * 16384;
        y = y_in * 16384;
        z = 0;
        sh = FRAC_BITS - 16;
        if (x_in == 0 && y_in == 0) return 0;
        for (int i = 0; i < CSTEPS; i++)
        begin
            dx = x >>> i;
            dy = y >>> i;
            if (y >= 0)
            begin
                x = x + dy;
                y = y - dx;
                z = z + ATAN_DEG[i];
            end
            else
            begin
                x = x - dy;
                y = y + dx;
                z = z - ATAN_DEG[i];
            end
        end
        if (sh >= 0) return z * (longint'(1) << sh);
        return z >>> (-sh);
    endfunction

    function automatic logic signed [18:0] deg_to_rad(input longint deg);
        longint r;
        r = (deg * 74961321 + (longint'(1) << 31)) >>> 32;
        if (r > RAD_LIMIT) r = RAD_LIMIT;
        if (r < -RAD_LIMIT) r = -RAD_LIMIT;
        return r[18:0];
    endfunction

    task automatic filter_axis(input int a, input longint rate, input longint meas,
                               input longint dt);
        longint ang, p00, p01, p11, s, k0, k1, innov, omk;
        k0 = 0;
        k1 = 0;
        ang = clip32(ang_est[a] + by_dt(rate - bias_est[a], dt));
        p00 = clip32(p_aa[a] - 2 * by_dt(p_ab[a], dt) + by_dt(by_dt(p_bb[a], dt), dt)
                     + longint'(q_angle_r));
        p01 = clip32(p_ab[a] - by_dt(p_bb[a], dt));
        p11 = clip32(p_bb[a] + longint'(q_bias_r));
        s = p00 + longint'(r_meas_r);
        if (s > 0)
        begin
            k0 = clip32((p00 * ONE) / s);
            k1 = clip32((p01 * ONE) / s);
        end
        innov = clip32(meas - ang);
        ang_est[a] = clip32(ang + fx_mul(k0, innov));
        bias_est[a] = clip32(bias_est[a] + fx_mul(k1, innov));
        omk = clip32(ONE - k0);
        p_aa[a] = fx_mul(omk, p00);
        p_ab[a] = fx_mul(omk, p01);
        p_bb[a] = clip32(p11 - fx_mul(k1, p01));
    endtask

    task automatic predict_attitude(input logic [191:0] w);
        longint rate [3];
        longint meas [3];
        longint ax, ay, az, dt;
        attitude_t e;
        ax = longint'($signed(w[111:96]));
        ay = longint'($signed(w[127:112]));
        az = longint'($signed(w[143:128]));
        dt = longint'(w[191:176]);
        rate[0] = longint'($signed(w[31:0]));
        rate[1] = -longint'($signed(w[63:32]));
        rate[2] = -longint'($signed(w[95:64]));
        meas[0] = tilt_deg(ay, int_root(longint'(unsigned'(32'(ax * ax + az * az)))));
        meas[1] = tilt_deg(ax, int_root(longint'(unsigned'(32'(ay * ay + az * az)))));
        meas[2] = longint'($signed(w[175:144]));
        for (int a = 0; a < AXES && a < 3; a++)
            filter_axis(a, rate[a], meas[a], dt);
        e.roll  = (AXES > 0) ? deg_to_rad(ang_est[0]) : '0;
        e.pitch = (AXES > 1) ? deg_to_rad(ang_est[1]) : '0;
        e.yaw   = (AXES > 2) ? ang_est[2][31:0] : '0;
        attitude_q.push_back(e);
    endtask

    task automatic check_attitude(input logic [71:0] w);
        attitude_t e;
        attitude_t got;
        got.roll  = w[18:0];
        got.pitch = w[37:19];
        got.yaw   = w[69:38];
        if (attitude_q.size() == 0)
        begin
            $display("%0t: unexpected result word %h", $time, w);
            errors++;
            return;
        end
        e = attitude_q.pop_front();
        if (got.roll !== e.roll)
        begin
            $display("%0t: roll expected %0d got %0d", $time, e.roll, got.roll);
            errors++;
        end
        if (got.pitch !== e.pitch)
        begin
            $display("%0t: pitch expected %0d got %0d", $time, e.pitch, got.pitch);
            errors++;
        end
        if (got.yaw !== e.yaw)
        begin
            $display("%0t: yaw expected %0d got %0d", $time, e.yaw, got.yaw);
            errors++;
        end
        if (got.roll === e.roll && got.pitch === e.pitch && got.yaw === e.yaw)
            matched++;
    endtask

    initial
    begin
        errors = 0;
        matched = 0;
    end

    assign pending = attitude_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attitude_q.delete();
            q_angle_r = Q_ANGLE_RST;
            q_bias_r = Q_BIAS_RST;
            r_meas_r = R_MEAS_RST;
            for (int a = 0; a < 3; a++)
            begin
                ang_est[a] = 0;
                bias_est[a] = 0;
                p_aa[a] = ONE;
                p_ab[a] = 0;
                p_bb[a] = ONE;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_addr)
                    CFG_Q_ANGLE: q_angle_r = cfg_data[15:0];
                    CFG_Q_BIAS:  q_bias_r = cfg_data[15:0];
                    CFG_R_MEAS:  r_meas_r = cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
                check_attitude(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                predict_attitude(s_axis_tdata);
        end
    end

endmodule

@@ tb/testbench.sv @@
// Top of the attitude filter testbench: clock, reset, stimulus, register phases and verdict.
`timescale 1ns / 1ps
module testbench;
    import akf_pkg::*;

    localparam int LIMIT = 3000000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_addr = '0;
    logic [23:0]  cfg_data = '0;

    int  errors, pending, matched;
    int  sent = 0;
    int  cycles = 0;
    bit  calm = 1'b0;

    always #10 clk = ~clk;

    attitude_kalman_filter_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    akf_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .matched(matched)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    always @(negedge clk)
        if (rst_n)
            m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 24);

    function automatic logic [191:0] imu_word(input int gx, input int gy, input int gz,
                                               input shortint ax, input shortint ay,
                                               input shortint az, input int hdg,
                                               input logic [15:0] dt);
        return {dt, hdg, az, ay, ax, gz, gy, gx};
    endfunction

    task automatic send_imu(input logic [191:0] w);
        while (!calm && $urandom_range(99) < 24) @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = w;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_valid = 1'b1;
        cfg_addr = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain;
        while (pending != 0) @(negedge clk);
        repeat (500) @(negedge clk);
    endtask

    task automatic set_noise(input logic [15:0] qa, input logic [15:0] qb,
                             input logic [23:0] r);
        drain();
        write_reg(CFG_Q_ANGLE, qa);
        write_reg(CFG_Q_BIAS, qb);
        write_reg(CFG_R_MEAS, r);
    endtask

    task automatic random_imu(input int n);
        int g, h;
        for (int i = 0; i < n; i++)
        begin
            calm = (sent >= 320 && sent < 400);
            if ($urandom_range(99) < 15)
                send_imu({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            else
            begin
                g = 200 << 16;
                h = 180 << 16;
                send_imu(imu_word(int'($urandom_range(2 * g)) - g,
                                  int'($urandom_range(2 * g)) - g,
                                  int'($urandom_range(2 * g)) - g,
                                  shortint'(int'($urandom_range(34000)) - 17000),
                                  shortint'(int'($urandom_range(34000)) - 17000),
                                  shortint'(int'($urandom_range(34000)) - 17000),
                                  int'($urandom_range(2 * h)) - h,
                                  16'($urandom_range(50, 3000))));
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_imu(imu_word(0, 0, 0, 0, 0, 0, 0, 16'd655));
        send_imu(imu_word(0, 0, 0, 0, 0, 16384, 0, 16'd655));
        send_imu(imu_word(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                          16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'sh7FFFFFFF, 16'hFFFF));
        send_imu(imu_word(32'sh80000000, 32'sh80000000, 32'sh80000000,
                          16'sh8000, 16'sh8000, 16'sh8000, 32'sh80000000, 16'hFFFF));
        send_imu(imu_word(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                          16'sh8000, 16'sh7FFF, 0, 32'sh7FFFFFFF, 16'hFFFF));
        send_imu(imu_word(100 << 16, -(50 << 16), 10 << 16, 0, -16384, 0,
                          -(90 << 16), 16'd0));
        send_imu(imu_word(0, 0, 0, 16384, 0, 0, 45 << 16, 16'd1));
        send_imu(imu_word(0, 0, 0, -16384, 0, -1, 32'sh80000000, 16'd1000));
        send_imu(imu_word(-1, -1, -1, -1, -1, -1, -1, 16'hFFFF));
        send_imu(imu_word(0, 0, 0, 0, 16'sh8000, 16'sh8000, 0, 16'd0));
        set_noise(16'd0, 16'd0, 24'd1);
        send_imu(imu_word(0, 0, 0, 100, -200, 16000, 10 << 16, 16'd655));
        send_imu(imu_word(32'sh7FFFFFFF, 0, 0, 0, 0, 0, 32'sh7FFFFFFF, 16'hFFFF));
        send_imu(imu_word(0, 32'sh7FFFFFFF, 0, 0, 0, 0, 32'sh80000000, 16'hFFFF));
        set_noise(16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        send_imu(imu_word(5 << 16, 5 << 16, 5 << 16, 300, 300, 16000, 1 << 16, 16'd655));
        send_imu(imu_word(32'sh80000000, 0, 32'sh7FFFFFFF, 0, 0, 0, 0, 16'hFFFF));

        random_imu(150);
        set_noise(16'd0, 16'd0, 24'd1);
        random_imu(150);
        set_noise(16'($urandom), 16'($urandom), 24'($urandom_range(1, 24'hFFFFFF)));
        random_imu(150);
        set_noise(16'd66, 16'd197, 24'd65536);
        random_imu(150);
        set_noise(16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        random_imu(100);
        drain();

        $display("Sent %0d sensor words over five noise settings, %0d results matched.",
                 sent, matched);
        $display("Register extremes, zero tilt vector and saturating inputs included.");
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
